@@ sv/alarm_annunciator_led_relay_macros.svh @@
// ----------------------------------------------------------------------------
// Alarm annunciator assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALARM_ANNUNCIATOR_LED_RELAY_MACROS_SVH
`define ALARM_ANNUNCIATOR_LED_RELAY_MACROS_SVH

// check that a condition holds at every edge
`define AALR_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// check that a condition holds in the cycle after a trigger
`define AALR_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ sv/aalr_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm annunciator package
// Widths, codes, configuration and item types, LED pattern and counter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package aalr_pkg;

    localparam int TIME_WIDTH = 24;
    localparam int CMD_W      = 2;
    localparam int CODE_W     = 3;
    localparam int DT_W       = 16;
    localparam int HALF_W     = 16;
    localparam int LIM_W      = 24;
    localparam int CNT_W      = 17;
    localparam int CMP_W      = (TIME_WIDTH > LIM_W) ? TIME_WIDTH : LIM_W;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [HALF_W-1:0] SLOW_HALF_RST    = HALF_W'(500);
    localparam logic [HALF_W-1:0] FAST_HALF_RST    = HALF_W'(250);
    localparam logic [HALF_W-1:0] RELAY_PHASE_RST  = HALF_W'(1000);
    localparam logic [LIM_W-1:0]  SHORT_TIMEOUT_RST = LIM_W'(1000);
    localparam logic [LIM_W-1:0]  LONG_TIMEOUT_RST  = LIM_W'(60 * 1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_e;

    localparam logic [CODE_W-1:0] ALM_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] ALM_X        = 3'd1;
    localparam logic [CODE_W-1:0] ALM_Y        = 3'd2;
    localparam logic [CODE_W-1:0] ALM_XY       = 3'd3;
    localparam logic [CODE_W-1:0] ALM_DIP      = 3'd4;
    localparam logic [CODE_W-1:0] ALM_SOFTWARE = 3'd5;
    localparam logic [CODE_W-1:0] ALM_HARDWARE = 3'd6;
    localparam logic [CODE_W-1:0] ALM_INVALID  = 3'd7;

    typedef enum logic [1:0] {
        LED_OFF  = 2'd0,
        LED_ON   = 2'd1,
        LED_SLOW = 2'd2,
        LED_FAST = 2'd3
    } led_mode_e;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLOW_FLASH    = 3'd0,
        REG_FAST_FLASH    = 3'd1,
        REG_RELAY_PHASE   = 3'd2,
        REG_SHORT_TIMEOUT = 3'd3,
        REG_LONG_TIMEOUT  = 3'd4
    } reg_idx_e;

    typedef struct packed {
        logic [HALF_W-1:0] slow_flash_half_ms;
        logic [HALF_W-1:0] fast_flash_half_ms;
        logic [HALF_W-1:0] relay_phase_ms;
        logic [LIM_W-1:0]  short_timeout_ms;
        logic [LIM_W-1:0]  long_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CODE_W-1:0] alarm_code;
        logic [DT_W-1:0]   elapsed_ms;
    } item_t;

    typedef struct packed {
        logic              green_led;
        logic              red_led;
        logic              relay_level;
        logic [CODE_W-1:0] active_alarm;
    } result_t;

    typedef struct packed {
        led_mode_e green;
        led_mode_e red;
    } led_pair_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             lvl;
        logic             toggle;
    } led_upd_t;

    function automatic led_pair_t led_pattern(input logic [CODE_W-1:0] code);
        led_pair_t p;
        case (code)
            ALM_X:        p = '{green: LED_SLOW, red: LED_SLOW};
            ALM_Y:        p = '{green: LED_SLOW, red: LED_FAST};
            ALM_XY:       p = '{green: LED_SLOW, red: LED_ON};
            ALM_DIP:      p = '{green: LED_ON,   red: LED_ON};
            ALM_SOFTWARE: p = '{green: LED_OFF,  red: LED_ON};
            ALM_HARDWARE: p = '{green: LED_OFF,  red: LED_ON};
            default:      p = '{green: LED_SLOW, red: LED_OFF};
        endcase
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] cnt,
                                                 input logic [DT_W-1:0] dt);
        logic [CNT_W:0] s;
        s = {1'b0, cnt} + (CNT_W+1)'(dt);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic led_upd_t led_advance(input led_mode_e mode,
                                             input logic [CNT_W-1:0] cnt,
                                             input logic lvl,
                                             input logic [DT_W-1:0] dt,
                                             input logic [HALF_W-1:0] slow,
                                             input logic [HALF_W-1:0] fast);
        logic [CNT_W-1:0]  sum;
        logic [HALF_W-1:0] half;
        led_upd_t          upd;
        sum        = sat_cnt(cnt, dt);
        half       = (mode == LED_FAST) ? fast : slow;
        upd.cnt    = sum;
        upd.lvl    = lvl;
        upd.toggle = 1'b0;
        if ((mode == LED_SLOW || mode == LED_FAST) && sum >= CNT_W'(half))
        begin
            upd.lvl    = !lvl;
            upd.toggle = 1'b1;
            upd.cnt    = sum - CNT_W'(half);
        end
        return upd;
    endfunction

endpackage

`default_nettype wire

@@ sv/aalr_if.sv @@
// ----------------------------------------------------------------------------
// Alarm annunciator channels
// Valid/ready channels for command items and display result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface aalr_item_if;
    import aalr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [CODE_W-1:0]   alarm_code;
    logic [DT_W-1:0]     elapsed_ms;

    modport source (output valid, output cmd, output alarm_code, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input cmd, input alarm_code, input elapsed_ms,
                    output ready);
endinterface

interface aalr_result_if;
    import aalr_pkg::*;

    logic              valid;
    logic              ready;
    logic              green_led;
    logic              red_led;
    logic              relay_level;
    logic [CODE_W-1:0] active_alarm;

    modport source (output valid, output green_led, output red_led, output relay_level,
                    output active_alarm, input ready);
    modport sink   (input valid, input green_led, input red_led, input relay_level,
                    input active_alarm, output ready);
endinterface

`default_nettype wire

@@ sv/alarm_annunciator_led_relay.sv @@
// The result item for an accepted command is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle; the whole alarm, LED and relay update is one
// registered state step. A waiting result holds off the input until it is taken,
// and a new item enters in the same cycle that the waiting result leaves.
// Reset (rst_n low, asynchronous): no alarm shown, green slow flash, red off,
// relay inactive (high), configuration registers back to their default values.
// ----------------------------------------------------------------------------
// Alarm annunciator LED and relay controller
// Top level: item handshake, result register, configuration port and core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alarm_annunciator_led_relay_macros.svh"

module alarm_annunciator_led_relay
(
    input  logic                          clk,
    input  logic                          rst_n,
    aalr_item_if.sink                     din,
    aalr_result_if.source                 dout,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aalr_pkg::PADDR_W-1:0]  paddr,
    input  logic [aalr_pkg::PDATA_W-1:0]  pwdata,
    output logic [aalr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import aalr_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    accept;

    aalr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item.cmd        = din.cmd;
    assign item.alarm_code = din.alarm_code;
    assign item.elapsed_ms = din.elapsed_ms;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    aalr_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.green_led    = result_reg.green_led;
    assign dout.red_led      = result_reg.red_led;
    assign dout.relay_level  = result_reg.relay_level;
    assign dout.active_alarm = result_reg.active_alarm;

    `AALR_CHECK_NEXT(a_accept_gives_result, accept, dout.valid, "accepted item produced no result")
    `AALR_CHECK(a_stall_blocks_input, !(dout.valid && !dout.ready) || !din.ready, "item taken while result stalled")
    `AALR_CHECK_NEXT(a_idle_holds_valid, !accept && !(dout.valid && dout.ready), $stable(dout.valid), "result valid changed without a handshake")

endmodule

`default_nettype wire

@@ sv/aalr_regs.sv @@
// ----------------------------------------------------------------------------
// Alarm annunciator configuration registers
// APB-style write/read port for flash, relay phase and timeout settings.
// ----------------------------------------------------------------------------
`default_nettype none

module aalr_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aalr_pkg::PADDR_W-1:0]  paddr,
    input  logic [aalr_pkg::PDATA_W-1:0]  pwdata,
    output logic [aalr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output aalr_pkg::cfg_t                cfg
);
    import aalr_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_e idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_flash_half_ms <= SLOW_HALF_RST;
            cfg_reg.fast_flash_half_ms <= FAST_HALF_RST;
            cfg_reg.relay_phase_ms     <= RELAY_PHASE_RST;
            cfg_reg.short_timeout_ms   <= SHORT_TIMEOUT_RST;
            cfg_reg.long_timeout_ms    <= LONG_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SLOW_FLASH:    cfg_reg.slow_flash_half_ms <= pwdata[HALF_W-1:0];
                REG_FAST_FLASH:    cfg_reg.fast_flash_half_ms <= pwdata[HALF_W-1:0];
                REG_RELAY_PHASE:   cfg_reg.relay_phase_ms     <= pwdata[HALF_W-1:0];
                REG_SHORT_TIMEOUT: cfg_reg.short_timeout_ms   <= pwdata[LIM_W-1:0];
                REG_LONG_TIMEOUT:  cfg_reg.long_timeout_ms    <= pwdata[LIM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SLOW_FLASH:    prdata = PDATA_W'(cfg_reg.slow_flash_half_ms);
            REG_FAST_FLASH:    prdata = PDATA_W'(cfg_reg.fast_flash_half_ms);
            REG_RELAY_PHASE:   prdata = PDATA_W'(cfg_reg.relay_phase_ms);
            REG_SHORT_TIMEOUT: prdata = PDATA_W'(cfg_reg.short_timeout_ms);
            REG_LONG_TIMEOUT:  prdata = PDATA_W'(cfg_reg.long_timeout_ms);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/aalr_core.sv @@
// ----------------------------------------------------------------------------
// Alarm annunciator core
// Alarm accumulate/commit, LED flash timing, alarm timeout and relay pulser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alarm_annunciator_led_relay_macros.svh"

module aalr_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  aalr_pkg::item_t   item,
    input  aalr_pkg::cfg_t    cfg,
    output aalr_pkg::result_t result
);
    import aalr_pkg::*;

    typedef enum logic [2:0] {
        RLY_RESET       = 3'd0,
        RLY_START       = 3'd1,
        RLY_IDLE        = 3'd2,
        RLY_ACT_START   = 3'd3,
        RLY_ACT_WAIT    = 3'd4,
        RLY_INACT_START = 3'd5,
        RLY_INACT_WAIT  = 3'd6
    } relay_state_e;

    logic [CODE_W-1:0]         acc_reg, acc_next;
    logic [CODE_W-1:0]         shown_reg, shown_next;
    logic [CODE_W-1:0]         alarm_edge_reg, alarm_edge_next;
    logic                      run_reg, run_next;
    logic [TIME_WIDTH-1:0]     age_reg, age_next;
    logic [LIM_W-1:0]          limit_reg, limit_next;
    led_mode_e [1:0]           mode_reg, mode_next;
    logic [1:0][CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]                lvl_reg, lvl_next;
    logic [1:0]                drive_reg, drive_next;
    relay_state_e              rstate_reg, rstate_next;
    logic [CNT_W-1:0]          rcnt_reg, rcnt_next;
    logic                      pin_reg, pin_next;

    led_upd_t                  led_upd [2];
    logic [TIME_WIDTH:0]       age_sum;
    logic [TIME_WIDTH-1:0]     age_sat;
    logic [CNT_W-1:0]          rcnt_sum;
    logic                      start_en;
    logic [CODE_W-1:0]         start_code;
    led_pair_t                 start_pat;

    assign led_upd[0] = led_advance(mode_reg[0], cnt_reg[0], lvl_reg[0], item.elapsed_ms,
                                    cfg.slow_flash_half_ms, cfg.fast_flash_half_ms);
    assign led_upd[1] = led_advance(mode_reg[1], cnt_reg[1], lvl_reg[1], item.elapsed_ms,
                                    cfg.slow_flash_half_ms, cfg.fast_flash_half_ms);
    assign age_sum    = {1'b0, age_reg} + (TIME_WIDTH+1)'(item.elapsed_ms);
    assign age_sat    = age_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : age_sum[TIME_WIDTH-1:0];
    assign rcnt_sum   = sat_cnt(rcnt_reg, item.elapsed_ms);
    assign start_pat  = led_pattern(start_code);

    always_comb
    begin
        acc_next        = acc_reg;
        shown_next      = shown_reg;
        alarm_edge_next = alarm_edge_reg;
        run_next        = run_reg;
        age_next        = age_reg;
        limit_next      = limit_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        lvl_next        = lvl_reg;
        drive_next      = drive_reg;
        rstate_next     = rstate_reg;
        rcnt_next       = rcnt_reg;
        pin_next        = pin_reg;
        start_en        = 1'b0;
        start_code      = ALM_NONE;

        if (accept)
        begin
            case (cmd_e'(item.cmd))
                CMD_CLEAR:
                begin
                    acc_next = ALM_NONE;
                end
                CMD_ACCUM:
                begin
                    if (item.alarm_code > acc_reg)
                    begin
                        acc_next = item.alarm_code;
                    end
                end
                CMD_COMMIT:
                begin
                    if (acc_reg != ALM_INVALID)
                    begin
                        if (acc_reg != ALM_NONE)
                        begin
                            alarm_edge_next = acc_reg;
                        end
                        if (shown_reg < acc_reg)
                        begin
                            start_en   = 1'b1;
                            start_code = acc_reg;
                        end
                        else if (acc_reg != ALM_NONE && shown_reg == acc_reg)
                        begin
                            age_next = '0;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (!run_reg)
                    begin
                        run_next   = 1'b1;
                        drive_next = lvl_reg;
                    end
                    else
                    begin
                        for (int k = 0; k < 2; k++)
                        begin
                            cnt_next[k] = led_upd[k].cnt;
                            lvl_next[k] = led_upd[k].lvl;
                            if (led_upd[k].toggle)
                            begin
                                drive_next[k] = led_upd[k].lvl;
                            end
                        end
                        if (shown_reg != ALM_NONE)
                        begin
                            if (limit_reg != '0)
                            begin
                                age_next = age_sat;
                            end
                            if (CMP_W'(age_next) >= CMP_W'(limit_reg))
                            begin
                                start_en   = 1'b1;
                                start_code = ALM_NONE;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (start_en)
            begin
                shown_next      = start_code;
                alarm_edge_next = start_code;
                age_next        = '0;
                run_next        = 1'b0;
                if (start_code inside {ALM_X, ALM_Y, ALM_XY, ALM_SOFTWARE})
                begin
                    limit_next = cfg.long_timeout_ms;
                end
                else
                begin
                    limit_next = cfg.short_timeout_ms;
                end
                mode_next[0] = start_pat.green;
                mode_next[1] = start_pat.red;
                cnt_next     = '0;
                lvl_next[0]  = (start_pat.green == LED_ON);
                lvl_next[1]  = (start_pat.red == LED_ON);
            end

            if (cmd_e'(item.cmd) == CMD_TICK)
            begin
                case (rstate_reg)
                    RLY_START:
                    begin
                        rstate_next = (alarm_edge_next != ALM_NONE) ? RLY_ACT_START
                                                                    : RLY_INACT_START;
                    end
                    RLY_IDLE:
                    begin
                        if (alarm_edge_next != ALM_NONE)
                        begin
                            rstate_next = RLY_ACT_START;
                        end
                    end
                    RLY_ACT_START:
                    begin
                        pin_next    = 1'b0;
                        rcnt_next   = '0;
                        rstate_next = RLY_ACT_WAIT;
                    end
                    RLY_ACT_WAIT:
                    begin
                        rcnt_next = rcnt_sum;
                        if (rcnt_sum >= CNT_W'(cfg.relay_phase_ms))
                        begin
                            rstate_next = RLY_INACT_START;
                        end
                    end
                    RLY_INACT_START:
                    begin
                        alarm_edge_next = ALM_NONE;
                        pin_next        = 1'b1;
                        rcnt_next       = '0;
                        rstate_next     = RLY_INACT_WAIT;
                    end
                    RLY_INACT_WAIT:
                    begin
                        rcnt_next = rcnt_sum;
                        if (rcnt_sum >= CNT_W'(cfg.relay_phase_ms))
                        begin
                            rstate_next = RLY_IDLE;
                        end
                    end
                    default:
                    begin
                        rstate_next = RLY_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= ALM_NONE;
            shown_reg      <= ALM_NONE;
            alarm_edge_reg <= ALM_NONE;
            run_reg        <= 1'b0;
            age_reg        <= '0;
            limit_reg      <= SHORT_TIMEOUT_RST;
            mode_reg[0]    <= LED_SLOW;
            mode_reg[1]    <= LED_OFF;
            cnt_reg        <= '0;
            lvl_reg        <= '0;
            drive_reg      <= '0;
            rstate_reg     <= RLY_RESET;
            rcnt_reg       <= '0;
            pin_reg        <= 1'b1;
        end
        else
        begin
            acc_reg        <= acc_next;
            shown_reg      <= shown_next;
            alarm_edge_reg <= alarm_edge_next;
            run_reg        <= run_next;
            age_reg        <= age_next;
            limit_reg      <= limit_next;
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            lvl_reg        <= lvl_next;
            drive_reg      <= drive_next;
            rstate_reg     <= rstate_next;
            rcnt_reg       <= rcnt_next;
            pin_reg        <= pin_next;
        end
    end

    assign result.green_led    = drive_next[0];
    assign result.red_led      = drive_next[1];
    assign result.relay_level  = pin_next;
    assign result.active_alarm = shown_next;

    `AALR_CHECK(a_pin_low_in_active_phase, (rstate_reg == RLY_ACT_WAIT || rstate_reg == RLY_INACT_START) == !pin_reg, "relay pin level disagrees with relay state")
    `AALR_CHECK(a_steady_led_level, (mode_reg[0] != LED_ON || lvl_reg[0]) && (mode_reg[0] != LED_OFF || !lvl_reg[0]) && (mode_reg[1] != LED_ON || lvl_reg[1]) && (mode_reg[1] != LED_OFF || !lvl_reg[1]), "steady LED mode with wrong level")
    `AALR_CHECK(a_no_alarm_pattern, shown_reg != ALM_NONE || (mode_reg[0] == LED_SLOW && mode_reg[1] == LED_OFF), "no-alarm display without its LED pattern")

endmodule

`default_nettype wire
